>>> design/rgl_pkg.sv
`default_nettype none

package rgl_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [CNT_WIDTH-1:0]  cnt_t;

	localparam data_t DATA_MAX = {DATA_WIDTH{1'b1}};

	typedef enum logic {
		DM_DIV,
		DM_MUL
	} dm_op_t;

	typedef struct packed {
		logic   start;
		dm_op_t op;
	} dm_ctl_t;

	typedef struct packed {
		logic done;
		logic hi_nz;
	} dm_sts_t;

endpackage

`default_nettype wire

>>> design/rgl_gcd.sv
`default_nettype none

module rgl_gcd (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rgl_pkg::data_t a,
	input  wire rgl_pkg::data_t b,
	output logic               done,
	output rgl_pkg::data_t     res
);

	logic           busy_q;
	logic           done_q;
	rgl_pkg::data_t a_q;
	rgl_pkg::data_t b_q;
	rgl_pkg::data_t res_q;
	rgl_pkg::cnt_t  k_q;

	logic           ge;
	rgl_pkg::data_t sub_x;
	rgl_pkg::data_t sub_y;
	rgl_pkg::data_t mag;

	// one compare and one subtract per step
	always_comb begin
		ge    = (a_q >= b_q);
		sub_x = ge ? a_q : b_q;
		sub_y = ge ? b_q : a_q;
		mag   = sub_x - sub_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if ((a == '0) || (b == '0)) begin
					// gcd with zero is the other operand
					res_q  <= a | b;
					done_q <= 1'b1;
				end else begin
					a_q    <= a;
					b_q    <= b;
					k_q    <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (a_q == b_q) begin
					res_q  <= a_q << k_q;
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + rgl_pkg::cnt_t'(1);
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (ge) begin
					a_q <= mag;
				end else begin
					b_q <= mag;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

>>> design/rgl_divmul.sv
`default_nettype none

module rgl_divmul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rgl_pkg::dm_ctl_t ctl,
	input  wire rgl_pkg::data_t   a,
	input  wire rgl_pkg::data_t   b,
	output rgl_pkg::dm_sts_t      sts,
	output rgl_pkg::data_t        res
);

	localparam int W = rgl_pkg::DATA_WIDTH;
	localparam rgl_pkg::cnt_t LAST = rgl_pkg::cnt_t'(W - 1);

	logic             busy_q;
	logic             done_q;
	rgl_pkg::dm_op_t  op_q;
	rgl_pkg::cnt_t    cnt_q;
	rgl_pkg::data_t   r_q;   // remainder, or high half of the product
	rgl_pkg::data_t   qd_q;  // dividend then quotient, or multiplier then low half
	rgl_pkg::data_t   b_q;

	logic [W:0]   add_x;
	logic [W:0]   add_y;
	logic         add_cin;
	logic [W+1:0] sum;

	// single shared adder: trial subtract for divide, accumulate for multiply
	always_comb begin
		if (op_q == rgl_pkg::DM_DIV) begin
			add_x   = {r_q, qd_q[W-1]};
			add_y   = ~{1'b0, b_q};
			add_cin = 1'b1;
		end else begin
			add_x   = {1'b0, r_q};
			add_y   = qd_q[0] ? {1'b0, b_q} : '0;
			add_cin = 1'b0;
		end
		sum = {1'b0, add_x} + {1'b0, add_y} + {{(W + 1){1'b0}}, add_cin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= rgl_pkg::DM_DIV;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				op_q   <= ctl.op;
				cnt_q  <= '0;
				r_q    <= '0;
				qd_q   <= a;
				b_q    <= b;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (op_q == rgl_pkg::DM_DIV) begin
					// carry out means no borrow: keep the difference
					r_q  <= sum[W+1] ? sum[W-1:0] : add_x[W-1:0];
					qd_q <= {qd_q[W-2:0], sum[W+1]};
				end else begin
					r_q  <= sum[W:1];
					qd_q <= {sum[0], qd_q[W-1:1]};
				end
				cnt_q <= cnt_q + rgl_pkg::cnt_t'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		sts.done  = done_q;
		sts.hi_nz = |r_q;
	end

	assign res = qd_q;

endmodule

`default_nettype wire

>>> design/running_gcd_lcm_unit.sv
// Running gcd and lcm of a stream of integer lists.
// Item channel: item_valid/item_stall carry value and first; first set opens
// a new list with that value. Result channel: result_valid/result_stall carry
// gcd_so_far, lcm_so_far and lcm_overflow, one result for every item.
// One item is worked on at a time; item_stall is high from the transfer
// until the result has been written to the output register.
// An item that opens a list goes straight to the commit. Otherwise a binary
// gcd runs on the shared subtract/shift unit. Each subtract of two odd
// operands leaves an even difference and each shift drops a bit. A saturated
// list or a zero value then goes straight to the commit.
// When the multiple must be worked out, a second gcd follows, then a W-step
// divide and a W-step multiply (W = 32) on one shared adder.
// The multiple saturates at all ones and lcm_overflow stays set until the
// next list starts.
// Reset clears the running gcd, lcm and overflow flag to zero and empties the
// output register. While the receiver stalls, the result holds; a new item can
// be taken and worked on, and its result waits until the output is free.
`default_nettype none

module running_gcd_lcm_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire rgl_pkg::data_t value,
	input  wire logic          first,
	output logic               result_valid,
	input  wire logic          result_stall,
	output rgl_pkg::data_t     gcd_so_far,
	output rgl_pkg::data_t     lcm_so_far,
	output logic               lcm_overflow
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_G1,
		S_G2,
		S_DIV,
		S_MUL,
		S_FIN
	} state_t;

	state_t         state_q;
	rgl_pkg::data_t v_q;
	rgl_pkg::data_t gnew_q;
	rgl_pkg::data_t lnew_q;
	logic           onew_q;
	rgl_pkg::data_t gcd_q;
	rgl_pkg::data_t lcm_q;
	logic           ovf_q;
	logic           result_valid_q;

	logic              accept;
	logic              out_free;
	logic              gcd_start;
	rgl_pkg::data_t    gcd_a;
	rgl_pkg::data_t    gcd_b;
	logic              gcd_done;
	rgl_pkg::data_t    gcd_res;
	rgl_pkg::dm_ctl_t  dm_ctl;
	rgl_pkg::data_t    dm_a;
	rgl_pkg::data_t    dm_b;
	rgl_pkg::dm_sts_t  dm_sts;
	rgl_pkg::data_t    dm_res;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && (state_q == S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;

	rgl_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (gcd_a),
		.b      (gcd_b),
		.done   (gcd_done),
		.res    (gcd_res)
	);

	rgl_divmul u_divmul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dm_ctl),
		.a      (dm_a),
		.b      (dm_b),
		.sts    (dm_sts),
		.res    (dm_res)
	);

	// launch the shared units on the cycle each step completes
	always_comb begin
		gcd_start    = 1'b0;
		gcd_a        = gcd_q;
		gcd_b        = value;
		dm_ctl.start = 1'b0;
		dm_ctl.op    = rgl_pkg::DM_DIV;
		dm_a         = lcm_q;
		dm_b         = gcd_res;
		case (state_q)
			S_IDLE: begin
				gcd_start = accept && !first;
			end
			S_G1: begin
				gcd_a = lcm_q;
				gcd_b = v_q;
				gcd_start = gcd_done && !ovf_q && (lcm_q != '0) && (v_q != '0);
			end
			S_G2: begin
				dm_ctl.start = gcd_done;
			end
			S_DIV: begin
				dm_ctl.start = dm_sts.done;
				dm_ctl.op    = rgl_pkg::DM_MUL;
				dm_a         = dm_res;
				dm_b         = v_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			gcd_q          <= '0;
			lcm_q          <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						v_q <= value;
						if (first) begin
							gnew_q  <= value;
							lnew_q  <= value;
							onew_q  <= 1'b0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_G1;
						end
					end
				end
				S_G1: begin
					if (gcd_done) begin
						gnew_q <= gcd_res;
						onew_q <= ovf_q;
						if (ovf_q) begin
							lnew_q  <= rgl_pkg::DATA_MAX;
							state_q <= S_FIN;
						end else if ((lcm_q == '0) || (v_q == '0)) begin
							lnew_q  <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_G2;
						end
					end
				end
				S_G2: begin
					if (gcd_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dm_sts.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (dm_sts.done) begin
						// any high product bit means the multiple no longer fits
						if (dm_sts.hi_nz) begin
							lnew_q <= rgl_pkg::DATA_MAX;
							onew_q <= 1'b1;
						end else begin
							lnew_q <= dm_res;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register is free, then commit
					if (out_free) begin
						gcd_q          <= gnew_q;
						lcm_q          <= lnew_q;
						ovf_q          <= onew_q;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign gcd_so_far   = gcd_q;
	assign lcm_so_far   = lcm_q;
	assign lcm_overflow = ovf_q;

endmodule

`default_nettype wire

>>> tb/running_gcd_lcm_unit_tb.sv
`default_nettype none

module running_gcd_lcm_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;

	typedef struct {
		rgl_pkg::data_t value;
		logic           first;
	} list_item_t;

	typedef struct {
		rgl_pkg::data_t gcd;
		rgl_pkg::data_t lcm;
		logic           ovf;
	} list_totals_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	rgl_pkg::data_t value = '0;
	logic           first = 1'b0;
	logic           result_valid;
	logic           result_stall = 1'b0;
	rgl_pkg::data_t gcd_so_far;
	rgl_pkg::data_t lcm_so_far;
	logic           lcm_overflow;

	list_item_t   pending_items[$];
	list_totals_t expected_totals[$];

	// running state of the current list, as the block should hold it
	rgl_pkg::data_t list_gcd = '0;
	rgl_pkg::data_t list_lcm = '0;
	logic           list_ovf = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	int unsigned primes[8] = '{2, 3, 5, 7, 11, 13, 17, 31};

	running_gcd_lcm_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.first        (first),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.gcd_so_far   (gcd_so_far),
		.lcm_so_far   (lcm_so_far),
		.lcm_overflow (lcm_overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		while (b != 64'd0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// fold one accepted item into the list and queue the totals it must produce
	task automatic fold_item(rgl_pkg::data_t v, logic opens);
		logic [63:0] l;
		logic [63:0] g;
		logic [63:0] q;
		list_totals_t t;
		if (opens) begin
			list_gcd = v;
			list_lcm = v;
			list_ovf = 1'b0;
		end else begin
			l = 64'(list_lcm);
			list_gcd = rgl_pkg::data_t'(euclid_gcd(64'(list_gcd), 64'(v)));
			if (list_ovf) begin
				list_lcm = rgl_pkg::DATA_MAX;
			end else if (l == 64'd0 || v == '0) begin
				list_lcm = '0;
			end else begin
				g = euclid_gcd(l, 64'(v));
				q = l / g;
				if (q > 64'(rgl_pkg::DATA_MAX / v)) begin
					list_lcm = rgl_pkg::DATA_MAX;
					list_ovf = 1'b1;
				end else begin
					list_lcm = rgl_pkg::data_t'(q * 64'(v));
				end
			end
		end
		t.gcd = list_gcd;
		t.lcm = list_lcm;
		t.ovf = list_ovf;
		expected_totals.push_back(t);
	endtask

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic push_item(rgl_pkg::data_t v, logic opens);
		list_item_t it;
		it.value = v;
		it.first = opens;
		pending_items.push_back(it);
	endtask

	function automatic rgl_pkg::data_t pick_value(int style, rgl_pkg::data_t base);
		logic [63:0] acc;
		int unsigned p;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 2)
			return '0;
		if (roll < 4)
			return ($urandom_range(1) != 0) ? rgl_pkg::DATA_MAX
				: rgl_pkg::data_t'(32'h8000_0000);
		case (style)
			0: begin
				acc = 64'(base) * 64'($urandom_range(1, 12));
				if (acc > 64'(rgl_pkg::DATA_MAX))
					acc = 64'(base);
			end
			1: begin
				acc = 64'd1;
				repeat ($urandom_range(1, 12)) begin
					p = primes[$urandom_range(7)];
					if (acc * 64'(p) <= 64'(rgl_pkg::DATA_MAX))
						acc = acc * 64'(p);
				end
			end
			2: acc = 64'($urandom);
			default: acc = 64'($urandom_range(1, 40));
		endcase
		return rgl_pkg::data_t'(acc);
	endfunction

	// mostly well-formed lists sharing a flavour of values, a few stray items
	task automatic queue_lists(int n_items);
		int count;
		int len;
		int style;
		rgl_pkg::data_t base;
		count = 0;
		while (count < n_items) begin
			if ($urandom_range(99) < 8) begin
				push_item(pick_value($urandom_range(3), rgl_pkg::data_t'(1)), 1'b0);
				count++;
			end else begin
				len = $urandom_range(1, 8);
				style = $urandom_range(3);
				base = rgl_pkg::data_t'($urandom_range(1, 5000));
				push_item(pick_value(style, base), 1'b1);
				for (int i = 1; i < len; i++)
					push_item(pick_value(style, base), 1'b0);
				count += len;
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_totals.size() != 0)
			@(negedge clk);
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin : item_driver
		list_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			value <= '0;
			first <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				fold_item(value, first);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					item_valid <= 1'b1;
					value <= nxt.value;
					first <= nxt.first;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : result_monitor
		list_totals_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_totals.size() == 0) begin
					report_mismatch($sformatf("result with no item outstanding: gcd %0h lcm %0h",
						gcd_so_far, lcm_so_far));
				end else begin
					want = expected_totals.pop_front();
					if (gcd_so_far !== want.gcd)
						report_mismatch($sformatf("gcd_so_far %0h, want %0h",
							gcd_so_far, want.gcd));
					if (lcm_so_far !== want.lcm)
						report_mismatch($sformatf("lcm_so_far %0h, want %0h",
							lcm_so_far, want.lcm));
					if (lcm_overflow !== want.ovf)
						report_mismatch($sformatf("lcm_overflow %0b, want %0b",
							lcm_overflow, want.ovf));
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// drop the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// no list opened yet: lcm stays zero
		push_item(32'd12, 1'b0);
		push_item(32'd18, 1'b0);
		// extremes, overflow and a saturated list
		push_item(rgl_pkg::DATA_MAX, 1'b1);
		push_item(32'hFFFF_FFFE, 1'b0);
		push_item(32'd6, 1'b0);
		push_item(32'd1, 1'b1);
		push_item(32'h8000_0000, 1'b0);
		push_item(32'd3, 1'b0);
		push_item(32'd9, 1'b0);
		// zero values
		push_item(32'd12, 1'b1);
		push_item(32'd0, 1'b0);
		push_item(32'd8, 1'b0);
		push_item(32'd0, 1'b1);
		push_item(32'd0, 1'b0);
		push_item(32'd5, 1'b0);
		// multiple just fits, then overflows
		push_item(32'd65536, 1'b1);
		push_item(32'd65535, 1'b0);
		push_item(32'd2, 1'b0);
		push_item(32'd3, 1'b0);
		push_item(32'd7, 1'b0);
		push_item(32'h5555_5555, 1'b1);
		push_item(32'hAAAA_AAAA, 1'b0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			queue_lists(250);
			drain();
		end

		// catch any stray result
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
